### rtl/core/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types, constants and helpers for the bus slot filter with its
// receive and transmit rings.
// ----------------------------------------------------------------------------
package bsf_pkg;

    localparam int RX_DEPTH    = 32;
    localparam int TX_DEPTH    = 32;
    localparam int MSG_RESERVE = 18;

    localparam int RX_IDX_W  = $clog2(RX_DEPTH);
    localparam int TX_IDX_W  = $clog2(TX_DEPTH);
    localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);
    localparam int TX_THRESH = TX_DEPTH - MSG_RESERVE;

    localparam int WORD_W = 9;
    localparam int BYTE_W = 8;
    localparam int SLOT_W = 5;

    localparam int                CALL_BIT       = 8;
    localparam logic [1:0]        CALL_KIND_POLL = 2'b10;
    localparam logic [SLOT_W-1:0] BROADCAST_SLOT = '0;

    typedef logic [RX_IDX_W-1:0]  rx_idx_t;
    typedef logic [TX_IDX_W-1:0]  tx_idx_t;
    typedef logic [TX_FILL_W-1:0] tx_fill_t;
    typedef logic [SLOT_W-1:0]    slot_t;

    typedef enum logic [2:0] {
        OP_LINE_WORD  = 3'd0,
        OP_HOST_PUSH  = 3'd1,
        OP_HOST_POP   = 3'd2,
        OP_LINE_READY = 3'd3,
        OP_TX_DONE    = 3'd4,
        OP_CLEAR_TX   = 3'd5,
        OP_FLUSH_RX   = 3'd6,
        OP_NOP        = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        CMD_LINE,
        CMD_DROP,
        CMD_PUSH,
        CMD_POP,
        CMD_SEND,
        CMD_TX_DONE,
        CMD_CLEAR_TX,
        CMD_FLUSH_RX,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0]        operation;
        logic [WORD_W-1:0] line_word;
        logic              frame_error;
        logic [BYTE_W-1:0] host_byte;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] rx_word;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_byte_valid;
        logic              drive_enable;
        logic              rx_available;
        logic              tx_ready;
        logic              tx_empty;
        logic              tx_almost_full;
    } out_word_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [WORD_W-1:0] line_word;
        logic [BYTE_W-1:0] host_byte;
        logic              is_call;
        logic              is_inquiry;
    } cmd_t;

    function automatic rx_idx_t rx_next_idx(input rx_idx_t i);
        rx_idx_t r;
        if (i == RX_IDX_W'(RX_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + rx_idx_t'(1);
        end
        return r;
    endfunction

    function automatic tx_idx_t tx_next_idx(input tx_idx_t i);
        tx_idx_t r;
        if (i == TX_IDX_W'(TX_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + tx_idx_t'(1);
        end
        return r;
    endfunction

endpackage

### rtl/core/bsf_front.sv
// ----------------------------------------------------------------------------
// bsf_front
// Accepts input words, classifies them into commands and holds them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module bsf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bsf_pkg::in_word_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output bsf_pkg::cmd_t     cmd
);

    bsf_pkg::cmd_t q_mem [2];
    logic          q_wr_reg;
    logic          q_wr_next;
    logic          q_rd_reg;
    logic          q_rd_next;
    logic [1:0]    q_cnt_reg;
    logic [1:0]    q_cnt_next;
    logic          push;
    logic          pop;
    bsf_pkg::cmd_t decoded;

    // classification
    always_comb
    begin
        decoded            = '0;
        decoded.line_word  = in_data.line_word;
        decoded.host_byte  = in_data.host_byte;
        decoded.is_call    = in_data.line_word[bsf_pkg::CALL_BIT];
        decoded.is_inquiry = (in_data.line_word[6:5] == bsf_pkg::CALL_KIND_POLL);
        case (bsf_pkg::op_t'(in_data.operation))
            bsf_pkg::OP_LINE_WORD:
                decoded.kind = in_data.frame_error ? bsf_pkg::CMD_DROP : bsf_pkg::CMD_LINE;
            bsf_pkg::OP_HOST_PUSH:  decoded.kind = bsf_pkg::CMD_PUSH;
            bsf_pkg::OP_HOST_POP:   decoded.kind = bsf_pkg::CMD_POP;
            bsf_pkg::OP_LINE_READY: decoded.kind = bsf_pkg::CMD_SEND;
            bsf_pkg::OP_TX_DONE:    decoded.kind = bsf_pkg::CMD_TX_DONE;
            bsf_pkg::OP_CLEAR_TX:   decoded.kind = bsf_pkg::CMD_CLEAR_TX;
            bsf_pkg::OP_FLUSH_RX:   decoded.kind = bsf_pkg::CMD_FLUSH_RX;
            default:                decoded.kind = bsf_pkg::CMD_NOP;
        endcase
    end

    assign in_stall  = (q_cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_mem[q_rd_reg];

    always_comb
    begin
        q_wr_next  = push ? ~q_wr_reg : q_wr_reg;
        q_rd_next  = pop ? ~q_rd_reg : q_rd_reg;
        q_cnt_next = q_cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            q_wr_reg  <= q_wr_next;
            q_rd_reg  <= q_rd_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[q_wr_reg] <= decoded;
        end
    end

endmodule

### rtl/core/bsf_back.sv
// ----------------------------------------------------------------------------
// bsf_back
// Executes queued commands against the slot filter, the receive and
// transmit rings, and registers one result word per command.
// ----------------------------------------------------------------------------
module bsf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_enable,
    input  logic [4:0]         cfg_write_data,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  bsf_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_stall,
    output bsf_pkg::out_word_t out_data
);

    logic [bsf_pkg::WORD_W-1:0] rx_mem [bsf_pkg::RX_DEPTH];
    logic [bsf_pkg::BYTE_W-1:0] tx_mem [bsf_pkg::TX_DEPTH];

    bsf_pkg::rx_idx_t   rx_wr_reg, rx_wr_next;
    bsf_pkg::rx_idx_t   rx_rd_reg, rx_rd_next;
    bsf_pkg::tx_idx_t   tx_wr_reg, tx_wr_next;
    bsf_pkg::tx_idx_t   tx_rd_reg, tx_rd_next;
    bsf_pkg::tx_fill_t  tx_fill_reg, tx_fill_next;
    bsf_pkg::slot_t     slot_reg, slot_next;
    bsf_pkg::slot_t     own_reg;
    logic               sending_reg, sending_next;
    logic               driver_reg, driver_next;
    logic               rx_we;
    logic               tx_we;
    logic               out_valid_reg;
    bsf_pkg::out_word_t out_reg, out_next;
    logic               exec;

    assign exec    = cmd_valid && (!out_valid_reg || !out_stall);
    assign cmd_pop = exec;

    always_comb
    begin
        rx_wr_next   = rx_wr_reg;
        rx_rd_next   = rx_rd_reg;
        tx_wr_next   = tx_wr_reg;
        tx_rd_next   = tx_rd_reg;
        tx_fill_next = tx_fill_reg;
        slot_next    = slot_reg;
        sending_next = sending_reg;
        driver_next  = driver_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        out_next     = '0;
        case (cmd.kind)
            bsf_pkg::CMD_LINE:
            begin
                if (cmd.is_call)
                begin
                    slot_next = cmd.line_word[bsf_pkg::SLOT_W-1:0];
                    if (slot_next == own_reg && cmd.is_inquiry && tx_fill_reg != '0)
                    begin
                        driver_next  = 1'b1;
                        sending_next = 1'b1;
                    end
                end
                if (slot_next == bsf_pkg::BROADCAST_SLOT || slot_next == own_reg)
                begin
                    rx_we      = 1'b1;
                    rx_wr_next = bsf_pkg::rx_next_idx(rx_wr_reg);
                end
            end
            bsf_pkg::CMD_PUSH:
            begin
                if (tx_fill_reg < bsf_pkg::TX_FILL_W'(bsf_pkg::TX_DEPTH))
                begin
                    tx_we        = 1'b1;
                    tx_wr_next   = bsf_pkg::tx_next_idx(tx_wr_reg);
                    tx_fill_next = tx_fill_reg + bsf_pkg::tx_fill_t'(1);
                end
            end
            bsf_pkg::CMD_POP:
            begin
                if (rx_rd_reg != rx_wr_reg)
                begin
                    out_next.rx_word = rx_mem[rx_rd_reg];
                    rx_rd_next       = bsf_pkg::rx_next_idx(rx_rd_reg);
                end
            end
            bsf_pkg::CMD_SEND:
            begin
                if (sending_reg)
                begin
                    if (tx_fill_reg != '0)
                    begin
                        out_next.tx_byte       = tx_mem[tx_rd_reg];
                        out_next.tx_byte_valid = 1'b1;
                        tx_rd_next             = bsf_pkg::tx_next_idx(tx_rd_reg);
                        tx_fill_next           = tx_fill_reg - bsf_pkg::tx_fill_t'(1);
                    end
                    else
                    begin
                        sending_next = 1'b0;
                    end
                end
            end
            bsf_pkg::CMD_TX_DONE:
            begin
                driver_next = 1'b0;
            end
            bsf_pkg::CMD_CLEAR_TX:
            begin
                tx_wr_next   = tx_rd_reg;
                tx_fill_next = '0;
            end
            bsf_pkg::CMD_FLUSH_RX:
            begin
                rx_rd_next = '0;
                rx_wr_next = '0;
            end
            default:
            begin
            end
        endcase
        // status after the command
        out_next.drive_enable   = driver_next;
        out_next.rx_available   = (rx_rd_next != rx_wr_next);
        out_next.tx_ready       = (tx_fill_next < bsf_pkg::TX_FILL_W'(bsf_pkg::TX_THRESH));
        out_next.tx_empty       = (tx_fill_next == '0) && !driver_next;
        out_next.tx_almost_full = (tx_fill_next > bsf_pkg::TX_FILL_W'(bsf_pkg::TX_THRESH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg     <= '0;
            rx_rd_reg     <= '0;
            tx_wr_reg     <= '0;
            tx_rd_reg     <= '0;
            tx_fill_reg   <= '0;
            slot_reg      <= '0;
            own_reg       <= '0;
            sending_reg   <= 1'b0;
            driver_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                own_reg <= cfg_write_data;
            end
            if (exec)
            begin
                rx_wr_reg   <= rx_wr_next;
                rx_rd_reg   <= rx_rd_next;
                tx_wr_reg   <= tx_wr_next;
                tx_rd_reg   <= tx_rd_next;
                tx_fill_reg <= tx_fill_next;
                slot_reg    <= slot_next;
                sending_reg <= sending_next;
                driver_reg  <= driver_next;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_reg <= out_next;
        end
        if (exec && rx_we)
        begin
            rx_mem[rx_wr_reg] <= cmd.line_word;
        end
        if (exec && tx_we)
        begin
            tx_mem[tx_wr_reg] <= cmd.host_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_fill_reg <= bsf_pkg::TX_FILL_W'(bsf_pkg::TX_DEPTH))
        else $error("transmit fill beyond ring depth");

    a_send_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && cmd.kind == bsf_pkg::CMD_SEND && !sending_reg) |=> !out_reg.tx_byte_valid)
        else $error("byte sent while sending disabled");

    a_driver_with_send: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(driver_reg) |-> sending_reg)
        else $error("driver turned on without sending enabled");

    a_no_exec_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !exec)
        else $error("command executed over an untaken result");

endmodule

### rtl/core/bus_slot_filter_uart_fifo_top.sv
// ----------------------------------------------------------------------------
// bus_slot_filter_uart_fifo_top
// Half-duplex 9-bit bus slave front end: slot filter, receive ring and
// transmit ring behind a classify stage and a short command queue.
// ----------------------------------------------------------------------------
// path: the accepted input word is registered in the command queue, then executed
// into the registered result word; throughput: one word per cycle while out_stall
// is low, and the two-entry queue decouples input from output stall
// reset: indexes, fill, slot, send and driver flags and own address cleared;
// ring contents are not cleared and are undefined until written
module bus_slot_filter_uart_fifo_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_enable,
    input  logic [4:0]         cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  bsf_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bsf_pkg::out_word_t out_data
);

    logic          cmd_valid;
    logic          cmd_pop;
    bsf_pkg::cmd_t cmd;

    bsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    bsf_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .cmd_valid        (cmd_valid),
        .cmd_pop          (cmd_pop),
        .cmd              (cmd),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data)
    );

endmodule

### bench/bus_slot_filter_uart_fifo_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bus_slot_filter_uart_fifo_top_tb
// Drives line words, host pushes and pops, line-ready, tx-complete, clear and flush events
// into the bus slave front end under random valid and stall gaps. A local
// model of the slot filter and both rings predicts every status word, and
// each returned word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bus_slot_filter_uart_fifo_top_tb;

    localparam int ITEM_TARGET = 1650;
    localparam int CHUNK_ITEMS = 100;
    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD   = 60;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_enable;
    logic [4:0]         cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    bsf_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_stall;
    bsf_pkg::out_word_t out_data;

    // slave model state
    logic [bsf_pkg::WORD_W-1:0] rx_mem [bsf_pkg::RX_DEPTH];
    logic [bsf_pkg::BYTE_W-1:0] tx_mem [bsf_pkg::TX_DEPTH];
    int                         rx_wr;
    int                         rx_rd;
    int                         tx_wr;
    int                         tx_rd;
    int                         tx_count;
    bsf_pkg::slot_t             cur_slot;
    logic                       send_on;
    logic                       driver_up;
    bsf_pkg::slot_t             own_addr_cfg;

    bsf_pkg::in_word_t  words_to_send [$];
    bsf_pkg::out_word_t due_results [$];
    bsf_pkg::out_word_t want;

    int   item_count;
    int   mismatch_count;
    int   quiet_cycles;
    int   send_gap;
    int   rcv_wait;
    int   hold_left;
    int   hold_request;
    logic idling;
    logic word_taken;
    logic result_taken;

    bus_slot_filter_uart_fifo_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bsf_pkg::out_word_t slave_step(input bsf_pkg::in_word_t w);
        bsf_pkg::out_word_t r;
        r = '0;
        case (bsf_pkg::op_t'(w.operation))
            bsf_pkg::OP_LINE_WORD:
            begin
                if (!w.frame_error)
                begin
                    if (w.line_word[bsf_pkg::CALL_BIT])
                    begin
                        cur_slot = w.line_word[bsf_pkg::SLOT_W-1:0];
                        if (cur_slot == own_addr_cfg
                            && w.line_word[6:5] == bsf_pkg::CALL_KIND_POLL
                            && tx_count != 0)
                        begin
                            driver_up = 1'b1;
                            send_on   = 1'b1;
                        end
                    end
                    if (cur_slot == bsf_pkg::BROADCAST_SLOT || cur_slot == own_addr_cfg)
                    begin
                        rx_mem[rx_wr] = w.line_word;
                        rx_wr = (rx_wr + 1) % bsf_pkg::RX_DEPTH;
                    end
                end
            end
            bsf_pkg::OP_HOST_PUSH:
            begin
                if (tx_count < bsf_pkg::TX_DEPTH)
                begin
                    tx_mem[tx_wr] = w.host_byte;
                    tx_wr = (tx_wr + 1) % bsf_pkg::TX_DEPTH;
                    tx_count++;
                end
            end
            bsf_pkg::OP_HOST_POP:
            begin
                if (rx_rd != rx_wr)
                begin
                    r.rx_word = rx_mem[rx_rd];
                    rx_rd = (rx_rd + 1) % bsf_pkg::RX_DEPTH;
                end
            end
            bsf_pkg::OP_LINE_READY:
            begin
                if (send_on)
                begin
                    if (tx_count != 0)
                    begin
                        r.tx_byte       = tx_mem[tx_rd];
                        r.tx_byte_valid = 1'b1;
                        tx_rd = (tx_rd + 1) % bsf_pkg::TX_DEPTH;
                        tx_count--;
                    end
                    else
                    begin
                        send_on = 1'b0;
                    end
                end
            end
            bsf_pkg::OP_TX_DONE:
            begin
                driver_up = 1'b0;
            end
            bsf_pkg::OP_CLEAR_TX:
            begin
                tx_wr    = tx_rd;
                tx_count = 0;
            end
            bsf_pkg::OP_FLUSH_RX:
            begin
                rx_rd = 0;
                rx_wr = 0;
            end
            default:
            begin
            end
        endcase
        r.drive_enable   = driver_up;
        r.rx_available   = (rx_rd != rx_wr);
        r.tx_ready       = (tx_count + bsf_pkg::MSG_RESERVE < bsf_pkg::TX_DEPTH);
        r.tx_empty       = (tx_count == 0 && !driver_up);
        r.tx_almost_full = (tx_count + bsf_pkg::MSG_RESERVE > bsf_pkg::TX_DEPTH);
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    // result monitor and predictor feed
    always @(posedge clk)
    begin
        word_taken   = rst_n && in_valid && !in_stall;
        result_taken = rst_n && out_valid && !out_stall;
        if (result_taken)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("rx_word", want.rx_word, out_data.rx_word);
                check_field("tx_byte", want.tx_byte, out_data.tx_byte);
                check_field("tx_byte_valid", want.tx_byte_valid, out_data.tx_byte_valid);
                check_field("drive_enable", want.drive_enable, out_data.drive_enable);
                check_field("rx_available", want.rx_available, out_data.rx_available);
                check_field("tx_ready", want.tx_ready, out_data.tx_ready);
                check_field("tx_empty", want.tx_empty, out_data.tx_empty);
                check_field("tx_almost_full", want.tx_almost_full, out_data.tx_almost_full);
            end
        end
        if (word_taken)
        begin
            due_results.push_back(slave_step(in_data));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (words_to_send.size() != 0)
            begin
                in_data  <= words_to_send.pop_front();
                in_valid <= 1'b1;
                send_gap = idling ? $urandom_range(0, 5) : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (result_taken)
            begin
                rcv_wait = idling ? $urandom_range(0, 5) : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rcv_wait > 0)
            begin
                rcv_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(input bsf_pkg::op_t op, input logic [8:0] word, input logic ferr,
                        input logic [7:0] hbyte);
        bsf_pkg::in_word_t w;
        w.operation   = op;
        w.line_word   = word;
        w.frame_error = ferr;
        w.host_byte   = hbyte;
        words_to_send.push_back(w);
        item_count++;
    endtask

    function automatic logic [8:0] call_word(input logic [1:0] kind,
                                             input bsf_pkg::slot_t slot);
        return {1'b1, 1'($urandom_range(0, 1)), kind, slot};
    endfunction

    task automatic set_own_address(input bsf_pkg::slot_t addr);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= addr;
        own_addr_cfg = addr;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (words_to_send.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_sequence();
        int             pick;
        int             n;
        int             readys;
        bsf_pkg::slot_t slot;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            // call then data words then pops
            n = $urandom_range(0, 9);
            slot = (n < 5) ? own_addr_cfg
                 : (n < 7) ? bsf_pkg::BROADCAST_SLOT
                 : bsf_pkg::slot_t'($urandom_range(0, 31));
            send(bsf_pkg::OP_LINE_WORD, call_word(2'($urandom_range(0, 3)), slot),
                 ($urandom_range(0, 9) == 0), 8'($urandom_range(0, 255)));
            n = $urandom_range(0, 6);
            repeat (n)
                send(bsf_pkg::OP_LINE_WORD, {1'b0, 8'($urandom_range(0, 255))},
                     ($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255)));
            n = $urandom_range(0, 4);
            repeat (n)
                send(bsf_pkg::OP_HOST_POP, 9'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        else if (pick < 62)
        begin
            // host queues a message, inquiry lets it out
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 10);
            repeat (n)
                send(bsf_pkg::OP_HOST_PUSH, 9'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            send(bsf_pkg::OP_LINE_WORD, call_word(bsf_pkg::CALL_KIND_POLL, own_addr_cfg),
                 1'b0, 8'($urandom_range(0, 255)));
            readys = ($urandom_range(0, 5) == 0) ? n / 2 : n + $urandom_range(0, 2);
            repeat (readys)
                send(bsf_pkg::OP_LINE_READY, 9'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) != 0)
                send(bsf_pkg::OP_TX_DONE, 9'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        else if (pick < 70)
        begin
            // receive ring overrun
            send(bsf_pkg::OP_LINE_WORD,
                 call_word(2'($urandom_range(0, 3)), bsf_pkg::BROADCAST_SLOT), 1'b0,
                 8'($urandom_range(0, 255)));
            n = $urandom_range(30, 40);
            repeat (n)
                send(bsf_pkg::OP_LINE_WORD, {1'b0, 8'($urandom_range(0, 255))}, 1'b0,
                     8'($urandom_range(0, 255)));
            n = $urandom_range(0, 40);
            repeat (n)
                send(bsf_pkg::OP_HOST_POP, 9'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send(bsf_pkg::op_t'(3'($urandom_range(0, 7))), 9'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int             phase;
        int             chunk_start;
        bsf_pkg::slot_t addr;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        in_data          = '0;
        out_stall        = 1'b0;
        rx_wr            = 0;
        rx_rd            = 0;
        tx_wr            = 0;
        tx_rd            = 0;
        tx_count         = 0;
        cur_slot         = '0;
        send_on          = 1'b0;
        driver_up        = 1'b0;
        own_addr_cfg     = '0;
        item_count       = 0;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        send_gap         = 0;
        rcv_wait         = 0;
        hold_left        = 0;
        hold_request     = 0;
        idling           = 1'b1;
        word_taken       = 1'b0;
        result_taken     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_own_address(bsf_pkg::slot_t'(5));
        send(bsf_pkg::OP_HOST_POP, 9'h000, 1'b0, 8'h00);
        send(bsf_pkg::OP_LINE_READY, 9'h1FF, 1'b1, 8'hFF);
        send(bsf_pkg::OP_NOP, 9'h1FF, 1'b1, 8'hFF);
        send(bsf_pkg::OP_TX_DONE, 9'h000, 1'b0, 8'h00);
        send(bsf_pkg::OP_LINE_WORD, 9'h000, 1'b0, 8'h00);
        send(bsf_pkg::OP_LINE_WORD, 9'h1FF, 1'b1, 8'h00);
        send(bsf_pkg::OP_LINE_WORD, 9'h105, 1'b0, 8'h00);
        send(bsf_pkg::OP_LINE_WORD, 9'h0FF, 1'b0, 8'h00);
        send(bsf_pkg::OP_HOST_PUSH, 9'h000, 1'b0, 8'hFF);
        send(bsf_pkg::OP_HOST_PUSH, 9'h1FF, 1'b1, 8'h00);
        send(bsf_pkg::OP_LINE_WORD, 9'h145, 1'b0, 8'h00);
        repeat (3) send(bsf_pkg::OP_LINE_READY, 9'h000, 1'b0, 8'h00);
        send(bsf_pkg::OP_TX_DONE, 9'h1FF, 1'b1, 8'hFF);
        send(bsf_pkg::OP_LINE_WORD, 9'h109, 1'b0, 8'h00);
        send(bsf_pkg::OP_LINE_WORD, 9'h0AA, 1'b0, 8'h00);
        repeat (5) send(bsf_pkg::OP_HOST_POP, 9'h000, 1'b0, 8'h00);
        send(bsf_pkg::OP_FLUSH_RX, 9'h000, 1'b0, 8'h00);
        send(bsf_pkg::OP_HOST_PUSH, 9'h000, 1'b0, 8'h5A);
        send(bsf_pkg::OP_CLEAR_TX, 9'h000, 1'b0, 8'h00);
        send(bsf_pkg::OP_LINE_WORD, 9'h145, 1'b0, 8'h00);
        send(bsf_pkg::OP_LINE_WORD, 9'h1FF, 1'b0, 8'h00);
        wait_drained();

        phase = 0;
        while (item_count < ITEM_TARGET)
        begin
            addr = (phase == 0) ? bsf_pkg::slot_t'(0)
                 : (phase == 1) ? bsf_pkg::slot_t'(31)
                 : bsf_pkg::slot_t'($urandom_range(0, 31));
            set_own_address(addr);
            for (int chunk = 0; chunk < 3; chunk++)
            begin
                // first chunk: receiver backs off while the sender keeps going
                idling = (chunk == 0) ? 1'b0 : (chunk == 1) ? 1'b1 : 1'($urandom_range(0, 1));
                if (chunk == 0)
                begin
                    hold_request = LONG_HOLD;
                end
                chunk_start = item_count;
                while (item_count - chunk_start < CHUNK_ITEMS && item_count < ITEM_TARGET)
                begin
                    add_sequence();
                end
                wait_drained();
            end
            phase++;
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && due_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
